// ===== hdl/khwu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khwu_pkg
// shared sizes, command codes and helpers of the hebbian weight update block
// ----------------------------------------------------------------------------
package khwu_pkg;

	localparam int UNITS    = 16;
	localparam int FEATURES = 64;
	localparam int BATCH    = 16;

	localparam int UW    = (UNITS > 1) ? $clog2(UNITS) : 1;
	localparam int FW    = (FEATURES > 1) ? $clog2(FEATURES) : 1;
	localparam int BW    = (BATCH > 1) ? $clog2(BATCH) : 1;
	localparam int RK_W  = $clog2(UNITS + 1);

	localparam int FUNC_W    = 3;
	localparam int IDX_W     = 6;
	localparam int VALUE_W   = 32;
	localparam int UPD_W     = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 1;

	localparam int LBL_W = 18;
	localparam int MB_W  = 48;
	localparam int ACC_W = 64;
	localparam int ST_W  = 48;
	localparam int Q_W   = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_RANK_K  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PENALTY = 1'b1;

	localparam logic signed [ST_W-1:0] SAT48 = {1'b0, {(ST_W-1){1'b1}}};

	typedef enum logic [FUNC_W-1:0] {
		FN_LOAD_W  = 3'd0,
		FN_LOAD_X  = 3'd1,
		FN_LOAD_A  = 3'd2,
		FN_COMPUTE = 3'd3,
		FN_READ    = 3'd4
	} func_t;

	typedef struct packed {
		logic clr;
		logic en;
	} mac_ctl_t;

	// +1.0 for the winner, -delta for the penalised unit, else 0 (q.16)
	function automatic logic signed [LBL_W-1:0] label_of(
		input logic [UW-1:0] win,
		input logic [UW-1:0] pen,
		input logic [UW-1:0] u,
		input logic [CFG_DATA_W-1:0] delta
	);
		logic signed [LBL_W-1:0] r;
		r = '0;
		if (win == u)
			r = LBL_W'(65536);
		else if (pen == u)
			r = -$signed({2'b00, delta});
		return r;
	endfunction

endpackage

// ===== hdl/khwu_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khwu_in_if
// command word channel: function code, indices and load value
// ----------------------------------------------------------------------------
interface khwu_in_if import khwu_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [FUNC_W-1:0]         func;
	logic [IDX_W-1:0]          row;
	logic [IDX_W-1:0]          col;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, func, row, col, value, input ready);
	modport sink   (input valid, func, row, col, value, output ready);
endinterface

// ===== hdl/khwu_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khwu_out_if
// result word channel: normalised update element and compute-done flag
// ----------------------------------------------------------------------------
interface khwu_out_if import khwu_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [UPD_W-1:0] update_value;
	logic                    done_res;

	modport source (output valid, update_value, done_res, input ready);
	modport sink   (input valid, update_value, done_res, output ready);
endinterface

// ===== hdl/krotov_hebbian_weight_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krotov_hebbian_weight_update
// hebbian / anti-hebbian weight update with per-row threshold and peak scaling
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    func, row, col, value
//  out_ch    out  valid/ready    update_value, done_res
//  cfg       in   cfg_we         cfg_index, cfg_data
//
//  loads are taken in idle and give no word; ready drops for compute and read
//  compute walks the stores with one shared mac unit, paced by that mac and by
//    the single read port of each store
//  a read in range with a nonzero peak waits on the 16-step serial divider
//  reset clears control, ranks, thresholds and peak; ram contents are unknown
//  a finished word waits in the output register while loads keep flowing
// ----------------------------------------------------------------------------
module krotov_hebbian_weight_update import khwu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	khwu_in_if.sink               in_ch,
	khwu_out_if.source            out_ch
);
	typedef enum logic [4:0] {
		S_IDLE, S_RK_A, S_RK_AL, S_RK_B, S_RK_BC,
		S_TH_I, S_TH_M, S_TH_D1, S_TH_D2,
		S_UP_SI, S_UP_SM, S_UP_WI, S_UP_WM, S_UP_D1, S_UP_D2,
		S_RD_I, S_RD_L, S_RD_W, S_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic [4:0]            rank_k_q;
	logic [CFG_DATA_W-1:0] delta_q;

	// loop counters
	logic [UW-1:0]   u_q, v_q;
	logic [BW-1:0]   s_q;
	logic [FW-1:0]   f_q;
	logic [RK_W-1:0] rank_q;
	logic signed [VALUE_W-1:0] a_q;

	// small per-sample and per-unit tables in flops
	logic [UW-1:0]          winner_q [BATCH];
	logic [UW-1:0]          pen_q    [BATCH];
	logic signed [ST_W-1:0] theta_q  [UNITS];
	logic [ST_W-1:0]        peak_q;

	// read path
	logic [IDX_W-1:0]   rr_q, rc_q;
	logic               pos_q;
	logic [UPD_W-1:0]   res_value_q;
	logic               res_done_q;

	// output register
	logic               out_valid_q;
	logic [UPD_W-1:0]   out_value_q;
	logic               out_done_q;

	// ram ports
	logic                  in_acc;
	logic                  row_u_ok, row_b_ok, col_f_ok, col_b_ok;
	logic                  w_we, x_we, a_we, upd_we;
	logic [UW+FW-1:0]      w_raddr, upd_raddr;
	logic [BW+FW-1:0]      x_raddr;
	logic [UW+BW-1:0]      a_raddr;
	logic [UPD_W-1:0]      w_rdata, x_rdata;
	logic [VALUE_W-1:0]    a_rdata;
	logic [ST_W-1:0]       upd_rdata;

	// shared units
	mac_ctl_t                mac_ctl;
	logic signed [LBL_W-1:0] mac_a;
	logic signed [MB_W-1:0]  mac_b;
	logic signed [ACC_W-1:0] mac_acc;
	logic                    div_start, div_busy, div_done;
	logic [ST_W-1:0]         div_num;
	logic [Q_W-1:0]          div_quot;

	logic signed [LBL_W-1:0] lbl;
	logic [6:0]              k_clamp;
	logic [RK_W-1:0]         pen_rank;
	logic                    outranks;
	logic [RK_W-1:0]         rank_next;
	logic signed [ST_W-1:0]  sat_val;
	logic [ST_W-1:0]         sat_mag;
	logic signed [ST_W-1:0]  rd_x;
	logic                    u_last, s_last, f_last, v_last;

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);

	assign row_u_ok = {1'b0, in_ch.row} < 7'(UNITS);
	assign row_b_ok = {1'b0, in_ch.row} < 7'(BATCH);
	assign col_f_ok = {1'b0, in_ch.col} < 7'(FEATURES);
	assign col_b_ok = {1'b0, in_ch.col} < 7'(BATCH);

	assign w_we   = in_acc && (in_ch.func == FN_LOAD_W) && row_u_ok && col_f_ok;
	assign x_we   = in_acc && (in_ch.func == FN_LOAD_X) && row_b_ok && col_f_ok;
	assign a_we   = in_acc && (in_ch.func == FN_LOAD_A) && row_u_ok && col_b_ok;
	assign upd_we = (state_q == S_UP_D2);

	assign u_last = (u_q == UW'(UNITS - 1));
	assign v_last = (v_q == UW'(UNITS - 1));
	assign s_last = (s_q == BW'(BATCH - 1));
	assign f_last = (f_q == FW'(FEATURES - 1));

	// ram read addresses follow the sequencer
	assign a_raddr   = (state_q == S_RK_B) ? {v_q, s_q} : {u_q, s_q};
	assign x_raddr   = {s_q, f_q};
	assign w_raddr   = {u_q, f_q};
	assign upd_raddr = {rr_q[UW-1:0], rc_q[FW-1:0]};

	khwu_ram #(.WIDTH(UPD_W), .DEPTH(2 ** (UW + FW))) u_w_ram (
		.clk(clk), .we(w_we), .waddr({in_ch.row[UW-1:0], in_ch.col[FW-1:0]}),
		.wdata(in_ch.value[UPD_W-1:0]), .raddr(w_raddr), .rdata(w_rdata)
	);

	khwu_ram #(.WIDTH(UPD_W), .DEPTH(2 ** (BW + FW))) u_x_ram (
		.clk(clk), .we(x_we), .waddr({in_ch.row[BW-1:0], in_ch.col[FW-1:0]}),
		.wdata(in_ch.value[UPD_W-1:0]), .raddr(x_raddr), .rdata(x_rdata)
	);

	khwu_ram #(.WIDTH(VALUE_W), .DEPTH(2 ** (UW + BW))) u_a_ram (
		.clk(clk), .we(a_we), .waddr({in_ch.row[UW-1:0], in_ch.col[BW-1:0]}),
		.wdata(in_ch.value), .raddr(a_raddr), .rdata(a_rdata)
	);

	khwu_ram #(.WIDTH(ST_W), .DEPTH(2 ** (UW + FW))) u_upd_ram (
		.clk(clk), .we(upd_we), .waddr({u_q, f_q}),
		.wdata(sat_val), .raddr(upd_raddr), .rdata(upd_rdata)
	);

	// clamp the penalty rank into 2..UNITS, compare against rank-1
	always_comb begin
		if (rank_k_q < 5'd2)
			k_clamp = 7'd2;
		else if ({2'b00, rank_k_q} > 7'(UNITS))
			k_clamp = 7'(UNITS);
		else
			k_clamp = {2'b00, rank_k_q};
		pen_rank = RK_W'(k_clamp - 7'd1);
	end

	// ranking: v outranks u on a larger activation, ties to the higher index
	assign outranks  = ($signed(a_rdata) > a_q) ||
		(($signed(a_rdata) == a_q) && (v_q > u_q));
	assign rank_next = rank_q + RK_W'(outranks);

	assign lbl = label_of(winner_q[s_q], pen_q[s_q], u_q, delta_q);

	// mac operand selection
	always_comb begin
		mac_ctl = '0;
		mac_a   = lbl;
		mac_b   = MB_W'($signed(a_rdata));
		case (state_q)
			S_TH_M: begin
				mac_ctl.en  = 1'b1;
				mac_ctl.clr = (s_q == '0);
			end
			S_UP_SM: begin
				mac_ctl.en  = 1'b1;
				mac_ctl.clr = (s_q == '0);
				mac_b       = MB_W'($signed(x_rdata));
			end
			S_UP_WM: begin
				mac_ctl.en = 1'b1;
				mac_a      = -LBL_W'($signed(w_rdata));
				mac_b      = theta_q[u_q];
			end
			default: begin
				mac_ctl = '0;
			end
		endcase
	end

	khwu_mac u_mac (
		.clk(clk), .arst_n(arst_n), .ctl(mac_ctl), .a(mac_a), .b(mac_b), .acc(mac_acc)
	);

	// saturate the raw update to +-(2^47-1)
	always_comb begin
		if (mac_acc > ACC_W'(SAT48))
			sat_val = SAT48;
		else if (mac_acc < -ACC_W'(SAT48))
			sat_val = -SAT48;
		else
			sat_val = ST_W'(mac_acc);
		sat_mag = sat_val[ST_W-1] ? ST_W'(-sat_val) : ST_W'(sat_val);
	end

	assign rd_x      = $signed(upd_rdata);
	assign div_start = (state_q == S_RD_L);
	assign div_num   = rd_x[ST_W-1] ? ST_W'(-rd_x) : ST_W'(rd_x);

	khwu_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(peak_q),
		.busy(div_busy), .done(div_done), .quot(div_quot)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_k_q <= 5'd2;
			delta_q  <= CFG_DATA_W'(26214);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RANK_K:  rank_k_q <= cfg_data[4:0];
				CFG_PENALTY: delta_q  <= cfg_data;
				default:     ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			u_q         <= '0;
			v_q         <= '0;
			s_q         <= '0;
			f_q         <= '0;
			rank_q      <= '0;
			a_q         <= '0;
			peak_q      <= '0;
			rr_q        <= '0;
			rc_q        <= '0;
			pos_q       <= 1'b0;
			res_value_q <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_done_q  <= 1'b0;
			res_done_q  <= 1'b0;
			for (int i = 0; i < BATCH; i++) begin
				winner_q[i] <= '0;
				pen_q[i]    <= '0;
			end
			for (int i = 0; i < UNITS; i++)
				theta_q[i] <= '0;
		end else begin
			// the finishing state reloads the register itself
			if (out_valid_q && out_ch.ready && (state_q != S_FIN))
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (in_ch.func)
							FN_COMPUTE: begin
								u_q     <= '0;
								s_q     <= '0;
								peak_q  <= '0;
								state_q <= S_RK_A;
							end
							FN_READ: begin
								rr_q    <= in_ch.row;
								rc_q    <= in_ch.col;
								state_q <= S_RD_I;
							end
							default: ;
						endcase
					end
				end
				S_RK_A: state_q <= S_RK_AL;
				S_RK_AL: begin
					a_q     <= $signed(a_rdata);
					v_q     <= '0;
					rank_q  <= '0;
					state_q <= S_RK_B;
				end
				S_RK_B: state_q <= S_RK_BC;
				S_RK_BC: begin
					if (v_last) begin
						if (rank_next == '0)
							winner_q[s_q] <= u_q;
						if (rank_next == pen_rank)
							pen_q[s_q] <= u_q;
						if (u_last) begin
							u_q <= '0;
							if (s_last) begin
								s_q     <= '0;
								state_q <= S_TH_I;
							end else begin
								s_q     <= s_q + 1'b1;
								state_q <= S_RK_A;
							end
						end else begin
							u_q     <= u_q + 1'b1;
							state_q <= S_RK_A;
						end
					end else begin
						v_q     <= v_q + 1'b1;
						rank_q  <= rank_next;
						state_q <= S_RK_B;
					end
				end
				S_TH_I: state_q <= S_TH_M;
				S_TH_M: begin
					if (s_last) begin
						state_q <= S_TH_D1;
					end else begin
						s_q     <= s_q + 1'b1;
						state_q <= S_TH_I;
					end
				end
				S_TH_D1: state_q <= S_TH_D2;
				S_TH_D2: begin
					// floor to q.16
					theta_q[u_q] <= ST_W'(mac_acc >>> 16);
					s_q          <= '0;
					if (u_last) begin
						u_q     <= '0;
						f_q     <= '0;
						state_q <= S_UP_SI;
					end else begin
						u_q     <= u_q + 1'b1;
						state_q <= S_TH_I;
					end
				end
				S_UP_SI: state_q <= S_UP_SM;
				S_UP_SM: begin
					if (s_last) begin
						s_q     <= '0;
						state_q <= S_UP_WI;
					end else begin
						s_q     <= s_q + 1'b1;
						state_q <= S_UP_SI;
					end
				end
				S_UP_WI: state_q <= S_UP_WM;
				S_UP_WM: state_q <= S_UP_D1;
				S_UP_D1: state_q <= S_UP_D2;
				S_UP_D2: begin
					if (sat_mag > peak_q)
						peak_q <= sat_mag;
					if (f_last) begin
						f_q <= '0;
						if (u_last) begin
							u_q         <= '0;
							res_value_q <= '0;
							res_done_q  <= 1'b1;
							state_q     <= S_FIN;
						end else begin
							u_q     <= u_q + 1'b1;
							state_q <= S_UP_SI;
						end
					end else begin
						f_q     <= f_q + 1'b1;
						state_q <= S_UP_SI;
					end
				end
				S_RD_I: begin
					res_done_q <= 1'b0;
					if (({1'b0, rr_q} >= 7'(UNITS)) || ({1'b0, rc_q} >= 7'(FEATURES)) ||
						(peak_q == '0)) begin
						res_value_q <= '0;
						state_q     <= S_FIN;
					end else begin
						state_q <= S_RD_L;
					end
				end
				S_RD_L: begin
					pos_q   <= !rd_x[ST_W-1] && (rd_x != '0);
					state_q <= S_RD_W;
				end
				S_RD_W: begin
					if (div_done) begin
						// positive raw update gives a negative word
						if (pos_q)
							res_value_q <= UPD_W'(17'd0 - {1'b0, div_quot});
						else if (div_quot[Q_W-1])
							res_value_q <= UPD_W'(16'h7fff);
						else
							res_value_q <= div_quot;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_value_q <= res_value_q;
						out_done_q  <= res_done_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.update_value = out_value_q;
	assign out_ch.done_res     = out_done_q;

	// a compute word never carries an update value
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.done_res |-> out_ch.update_value == '0)
		else $error("compute word carries a non-zero value");

	// compute and read hold off the next command word
	a_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (in_ch.func == FN_COMPUTE || in_ch.func == FN_READ) |=> !in_ch.ready)
		else $error("command word accepted without going busy");

	// peak is a saturated magnitude
	a_peak_bound: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q <= ST_W'(SAT48))
		else $error("peak exceeds saturation bound");

	// divider is only started when idle
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

endmodule

// ===== hdl/khwu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khwu_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module khwu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/khwu_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khwu_mac
// shared multiply-accumulate unit: registered product, then accumulate
// ----------------------------------------------------------------------------
module khwu_mac import khwu_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_ctl_t                ctl,
	input  logic signed [LBL_W-1:0] a,
	input  logic signed [MB_W-1:0]  b,
	output logic signed [ACC_W-1:0] acc
);
	logic signed [LBL_W+MB_W-1:0] full;
	logic signed [ACC_W-1:0]      prod_s1;
	logic                         en_s1;
	logic signed [ACC_W-1:0]      acc_q;

	assign full = a * b;
	assign acc  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
			acc_q <= '0;
		end else begin
			en_s1 <= ctl.en;
			acc_q <= (ctl.clr ? ACC_W'(0) : acc_q) + (en_s1 ? prod_s1 : ACC_W'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en)
			prod_s1 <= ACC_W'(full);
	end
endmodule

// ===== hdl/khwu_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khwu_div
// serial restoring divider: floor(num * 2^15 / den) for num <= den
// ----------------------------------------------------------------------------
module khwu_div import khwu_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [ST_W-1:0] num,
	input  logic [ST_W-1:0] den,
	output logic            busy,
	output logic            done,
	output logic [Q_W-1:0]  quot
);
	localparam int CNT_W = $clog2(Q_W + 1);

	logic [ST_W:0]    r_q;
	logic [ST_W-1:0]  den_q;
	logic [Q_W-1:0]   q_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ge;
	logic [ST_W:0]    r_next;

	assign ge     = r_q >= {1'b0, den_q};
	assign r_next = ge ? (r_q - {1'b0, den_q}) : r_q;
	assign busy   = busy_q;
	assign done   = done_q;
	assign quot   = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= {1'b0, num};
			den_q <= den;
			q_q   <= '0;
		end else if (busy_q) begin
			r_q <= {r_next[ST_W-1:0], 1'b0};
			q_q <= {q_q[Q_W-2:0], ge};
		end
	end
endmodule

// ===== verif/tb_krotov_hebbian_weight_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_krotov_hebbian_weight_update
// self-checking bench: loads every store, runs compute under several rank and
// penalty settings, reads the scaled update back and checks each result word
// against an in-bench fixed point predictor of the learning rule
// ----------------------------------------------------------------------------
module tb_krotov_hebbian_weight_update;
	import khwu_pkg::*;

	localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
	localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;
	localparam longint SAT_MAG = 64'sh7FFF_FFFF_FFFF;

	// ways of filling the activation store
	typedef enum int { FILL_RANDOM, FILL_TIES } fill_t;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [IDX_W-1:0]   row;
		logic [IDX_W-1:0]   col;
		logic [VALUE_W-1:0] value;
	} cmd_word_t;

	typedef struct packed {
		logic signed [UPD_W-1:0] upd;
		logic                    done;
	} res_word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	khwu_in_if  in_ch ();
	khwu_out_if out_ch ();

	krotov_hebbian_weight_update dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------- predictor
	// private copy of the block's stores and registers
	logic [4:0]  rank_sel;
	logic [15:0] delta_q16;
	shortint     w_mem [UNITS*FEATURES];
	shortint     x_mem [BATCH*FEATURES];
	int          a_mem [UNITS*BATCH];
	int          winner [BATCH];
	int          loser [BATCH];
	longint      theta [UNITS];
	longint      raw_upd [UNITS*FEATURES];
	longint unsigned peak_mag;

	cmd_word_t cmds_to_send [$];
	res_word_t results_due [$];

	int errors = 0;
	int n_checked = 0;
	int n_computes = 0;
	int n_reads = 0;

	function automatic longint label_weight(int u, int s);
		if (winner[s] == u)
			return 64'sd65536;
		if (loser[s] == u)
			return -longint'(delta_q16);
		return 0;
	endfunction

	// winner / penalised ranking, per-unit theta, raw update and its peak
	function automatic void recompute_update();
		int k;
		int rank;
		longint acc;
		longint unsigned mag;
		k = rank_sel;
		if (k < 2)
			k = 2;
		if (k > UNITS)
			k = UNITS;
		for (int s = 0; s < BATCH; s++) begin
			for (int u = 0; u < UNITS; u++) begin
				rank = 0;
				for (int v = 0; v < UNITS; v++) begin
					if (a_mem[v*BATCH+s] > a_mem[u*BATCH+s] ||
					    (a_mem[v*BATCH+s] == a_mem[u*BATCH+s] && v > u))
						rank++;
				end
				if (rank == 0)
					winner[s] = u;
				if (rank == k - 1)
					loser[s] = u;
			end
		end
		for (int u = 0; u < UNITS; u++) begin
			acc = 0;
			for (int s = 0; s < BATCH; s++)
				acc += label_weight(u, s) * longint'(a_mem[u*BATCH+s]);
			theta[u] = acc >>> 16;
		end
		peak_mag = 0;
		for (int u = 0; u < UNITS; u++) begin
			for (int f = 0; f < FEATURES; f++) begin
				acc = 0;
				for (int s = 0; s < BATCH; s++)
					acc += label_weight(u, s) * longint'(x_mem[s*FEATURES+f]);
				acc -= longint'(w_mem[u*FEATURES+f]) * theta[u];
				if (acc > SAT_MAG)
					acc = SAT_MAG;
				if (acc < -SAT_MAG)
					acc = -SAT_MAG;
				raw_upd[u*FEATURES+f] = acc;
				mag = (acc < 0) ? longint'(-acc) : longint'(acc);
				if (mag > peak_mag)
					peak_mag = mag;
			end
		end
	endfunction

	function automatic logic [UPD_W-1:0] scaled_update(int r, int c);
		longint x;
		longint unsigned mag;
		longint unsigned q;
		if (r >= UNITS || c >= FEATURES || peak_mag == 0)
			return '0;
		x = raw_upd[r*FEATURES+c];
		mag = (x < 0) ? longint'(-x) : longint'(x);
		q = (mag << 15) / peak_mag;
		if (x > 0)
			return UPD_W'(-longint'(q));
		if (q > 32767)
			q = 32767;
		return UPD_W'(q);
	endfunction

	// applies one accepted command word to the private state
	function automatic void predict_word(cmd_word_t w);
		int r;
		int c;
		r = w.row;
		c = w.col;
		case (w.func)
			FN_LOAD_W: begin
				if (r < UNITS && c < FEATURES)
					w_mem[r*FEATURES+c] = shortint'(w.value[15:0]);
			end
			FN_LOAD_X: begin
				if (r < BATCH && c < FEATURES)
					x_mem[r*FEATURES+c] = shortint'(w.value[15:0]);
			end
			FN_LOAD_A: begin
				if (r < UNITS && c < BATCH)
					a_mem[r*BATCH+c] = int'(w.value);
			end
			FN_COMPUTE: begin
				recompute_update();
				n_computes++;
				results_due.push_back('{upd: '0, done: 1'b1});
			end
			FN_READ: begin
				n_reads++;
				results_due.push_back('{upd: scaled_update(r, c), done: 1'b0});
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- driver
	logic quiet = 1'b0;
	int   send_gap = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_word(cmds_to_send[0]);
				void'(cmds_to_send.pop_front());
			end
			// a word still on offer stays put
			if (!(in_ch.valid && !in_ch.ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_ch.valid <= 1'b0;
				end else if (!quiet && $urandom_range(15) == 0) begin
					send_gap = $urandom_range(14, 1) - 1;
					in_ch.valid <= 1'b0;
				end else if (cmds_to_send.size() > 0) begin
					in_ch.valid <= 1'b1;
					in_ch.func  <= cmds_to_send[0].func;
					in_ch.row   <= cmds_to_send[0].row;
					in_ch.col   <= cmds_to_send[0].col;
					in_ch.value <= cmds_to_send[0].value;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	logic hold_go = 1'b0;
	int   take_gap = 0;
	res_word_t due;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				n_checked++;
				if (results_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected word upd=%0d done=%0b", $time,
						out_ch.update_value, out_ch.done_res);
				end else begin
					due = results_due.pop_front();
					if (out_ch.update_value !== due.upd) begin
						errors++;
						$display("%0t: update_value expected %0d actual %0d", $time,
							due.upd, out_ch.update_value);
					end
					if (out_ch.done_res !== due.done) begin
						errors++;
						$display("%0t: done_res expected %0b actual %0b", $time,
							due.done, out_ch.done_res);
					end
				end
			end
			// long hold-off so the block fills and stalls its input
			if (hold_go) begin
				hold_go = 1'b0;
				take_gap = 400;
			end
			if (take_gap > 0) begin
				take_gap--;
				out_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(11) == 0) begin
				take_gap = $urandom_range(14, 1) - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus
	function automatic void push_cmd(logic [FUNC_W-1:0] f, int r, int c, logic [31:0] v);
		cmd_word_t w;
		w.func  = f;
		w.row   = IDX_W'(r);
		w.col   = IDX_W'(c);
		w.value = v;
		cmds_to_send.push_back(w);
	endfunction

	// tie-heavy activations from a tiny set, extremes included
	function automatic logic [31:0] tie_value();
		case ($urandom_range(4))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'h0001_0000;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic void load_acts(fill_t mode);
		for (int u = 0; u < UNITS; u++)
			for (int s = 0; s < BATCH; s++)
				push_cmd(FN_LOAD_A, u, s, (mode == FILL_RANDOM) ? $urandom() : tie_value());
	endfunction

	function automatic void load_all(fill_t mode);
		for (int u = 0; u < UNITS; u++)
			for (int f = 0; f < FEATURES; f++)
				push_cmd(FN_LOAD_W, u, f, $urandom());
		for (int s = 0; s < BATCH; s++)
			for (int f = 0; f < FEATURES; f++)
				push_cmd(FN_LOAD_X, s, f, $urandom());
		load_acts(mode);
	endfunction

	function automatic void read_back(int n);
		for (int i = 0; i < n; i++)
			push_cmd(FN_READ, $urandom_range(UNITS-1), $urandom_range(FEATURES-1), $urandom());
	endfunction

	// loads, reads, out-of-range indices and spare codes, closed by a compute and 20 reads
	function automatic void mixed_phase(int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 20)
				push_cmd(FN_LOAD_W, $urandom_range(UNITS-1), $urandom_range(FEATURES-1),
					$urandom());
			else if (pick < 35)
				push_cmd(FN_LOAD_X, $urandom_range(BATCH-1), $urandom_range(FEATURES-1),
					$urandom());
			else if (pick < 50)
				push_cmd(FN_LOAD_A, $urandom_range(UNITS-1), $urandom_range(BATCH-1),
					($urandom_range(1)) ? $urandom() : tie_value());
			else if (pick < 85)
				read_back(1);
			else if (pick < 95)
				push_cmd(FUNC_W'($urandom_range(FN_READ, FN_LOAD_W)), $urandom_range(63, 16),
					$urandom_range(63), $urandom());
			else
				push_cmd(FUNC_W'($urandom_range(FN_SPARE_HI, FN_SPARE_LO)),
					$urandom_range(63), $urandom_range(63), $urandom());
		end
		push_cmd(FN_COMPUTE, $urandom_range(63), $urandom_range(63), $urandom());
		read_back(20);
	endfunction

	task automatic drain();
		while (cmds_to_send.size() > 0 || results_due.size() > 0)
			@(posedge clk);
		// a trailing load may still be in flight
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (idx == CFG_RANK_K)
			rank_sel = data[4:0];
		else
			delta_q16 = data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_ch.valid = 1'b0;
		in_ch.func  = '0;
		in_ch.row   = '0;
		in_ch.col   = '0;
		in_ch.value = '0;
		out_ch.ready = 1'b0;
		rank_sel  = 5'd2;
		delta_q16 = 16'd26214;
		peak_mag  = 0;
		for (int s = 0; s < BATCH; s++) begin
			winner[s] = 0;
			loser[s]  = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reads before any compute see a zero peak and return 0
		read_back(10);
		push_cmd(FN_READ, 63, 63, 32'h0);

		// every store filled before the first compute; directed corners on top
		load_all(FILL_RANDOM);
		push_cmd(FN_LOAD_W, 0, 0, 32'h0000_7FFF);
		push_cmd(FN_LOAD_W, UNITS-1, FEATURES-1, 32'hFFFF_8000);
		push_cmd(FN_LOAD_X, 0, 0, 32'h0000_8000);
		push_cmd(FN_LOAD_X, BATCH-1, FEATURES-1, 32'h0000_7FFF);
		push_cmd(FN_LOAD_A, 0, 0, 32'h7FFF_FFFF);
		push_cmd(FN_LOAD_A, 1, 0, 32'h7FFF_FFFF);
		push_cmd(FN_LOAD_A, UNITS-1, BATCH-1, 32'h8000_0000);
		push_cmd(FN_LOAD_W, 63, 63, 32'hFFFF_FFFF);
		push_cmd(FN_LOAD_X, 63, 0, 32'h0000_1234);
		push_cmd(FN_LOAD_A, 0, 63, 32'h1234_5678);
		push_cmd(FN_SPARE_LO, 0, 0, 32'hFFFF_FFFF);
		push_cmd(FN_SPARE_HI, 63, 63, 32'h0);
		push_cmd(FN_COMPUTE, 0, 0, 32'h0);
		push_cmd(FN_READ, 0, 0, 32'h0);
		push_cmd(FN_READ, UNITS-1, FEATURES-1, 32'h0);
		push_cmd(FN_READ, 63, 0, 32'h0);
		push_cmd(FN_READ, 0, 63, 32'h0);
		push_cmd(FN_READ, 63, 63, 32'h0);
		read_back(20);
		drain();

		// deepest rank, full penalty; long output hold-off part way in
		write_reg(CFG_RANK_K, 16'd16);
		write_reg(CFG_PENALTY, 16'hFFFF);
		mixed_phase(80);
		repeat (30) @(posedge clk);
		hold_go = 1'b1;
		drain();

		// rank below range and zero penalty with tie-heavy activations
		write_reg(CFG_RANK_K, 16'd0);
		write_reg(CFG_PENALTY, 16'h0000);
		load_acts(FILL_TIES);
		mixed_phase(40);
		drain();

		// rank above range, random penalty
		write_reg(CFG_RANK_K, 16'hFFFF);
		write_reg(CFG_PENALTY, 16'($urandom()));
		mixed_phase(40);
		drain();

		// last phase with no idling on either side
		quiet = 1'b1;
		write_reg(CFG_RANK_K, 16'($urandom_range(16, 2)));
		write_reg(CFG_PENALTY, 16'($urandom()));
		mixed_phase(40);
		drain();

		if (results_due.size() != 0) begin
			errors++;
			$display("%0t: %0d expected words never arrived", $time, results_due.size());
		end
		$display("run covered %0d checked words (%0d computes, %0d reads) over several",
			n_checked, n_computes, n_reads);
		$display("rank and penalty settings, ties, zero peak, out-of-range indices, spare codes");
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// watchdog: covers the run's computes with a wide margin
	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
